// File: rtl/lrsp_pkg.sv
// lrsp_pkg: shared types and constants of the load record stream parser
// parse phase and event codes, result record and field widths
// no dependencies
`timescale 1ns / 1ps

package lrsp_pkg;

    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 16;
    localparam int EVENT_W  = 3;
    localparam int STATUS_W = 2;

    // packed result word width, rounded up to whole bytes
    localparam int RES_BITS   = BYTE_W + 5 * WORD_W + STATUS_W;
    localparam int RES_DATA_W = ((RES_BITS + 7) / 8) * 8;

    localparam logic [BYTE_W-1:0] MAGIC_SECTION   = 8'h00;
    localparam logic [BYTE_W-1:0] MAGIC_POSTAMBLE = 8'hFF;
    localparam logic [BYTE_W-1:0] FILL_BYTE       = 8'h00;

    localparam logic [WORD_W-1:0] COUNT_MAX = '1;

    typedef enum logic [11:0] {
        PH_MAGIC_FIRST = 12'b0000_0000_0001,
        PH_LEN_HI      = 12'b0000_0000_0010,
        PH_LEN_LO      = 12'b0000_0000_0100,
        PH_ADDR_HI     = 12'b0000_0000_1000,
        PH_ADDR_LO     = 12'b0000_0001_0000,
        PH_DATA        = 12'b0000_0010_0000,
        PH_MAGIC_NEXT  = 12'b0000_0100_0000,
        PH_FILL_A      = 12'b0000_1000_0000,
        PH_FILL_B      = 12'b0001_0000_0000,
        PH_EXEC_HI     = 12'b0010_0000_0000,
        PH_EXEC_LO     = 12'b0100_0000_0000,
        PH_DONE        = 12'b1000_0000_0000
    } t_phase;

    typedef enum logic [EVENT_W-1:0] {
        EV_HEADER   = 3'd0,
        EV_SECTION  = 3'd1,
        EV_DATA     = 3'd2,
        EV_EXEC     = 3'd3,
        EV_WARN     = 3'd4,
        EV_BADMAGIC = 3'd5,
        EV_AFTEREND = 3'd6,
        EV_IGNORED  = 3'd7
    } t_event;

    localparam logic [STATUS_W-1:0] ST_NOT_LAST   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_COMPLETE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INCOMPLETE = 2'd2;

    typedef struct packed {
        t_event              ev;
        logic [BYTE_W-1:0]   data_byte;
        logic [WORD_W-1:0]   data_addr;
        logic [WORD_W-1:0]   section_addr;
        logic [WORD_W-1:0]   section_len;
        logic [WORD_W-1:0]   section_count;
        logic [WORD_W-1:0]   exec_addr;
        logic [STATUS_W-1:0] file_status;
    } t_result;

endpackage

// File: rtl/lrsp_core.sv
// lrsp_core: parse state registers and the per-byte next-state logic
// produces the result record of the byte being transferred
// depends on lrsp_pkg
`timescale 1ns / 1ps

module lrsp_core
    import lrsp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_last,
    output t_result           o_res
);

    t_phase            r_phase,    n_phase;
    logic [WORD_W-1:0] r_length,   n_length;
    logic [WORD_W-1:0] r_base,     n_base;
    logic [WORD_W-1:0] r_count,    n_count;
    logic [WORD_W-1:0] r_exec,     n_exec;
    logic [WORD_W-1:0] r_sections, n_sections;
    logic              r_aborted,  n_aborted;

    t_event            ev;
    logic [BYTE_W-1:0] dbyte;
    logic [WORD_W-1:0] daddr;
    logic [WORD_W-1:0] count_inc;

    assign count_inc = r_count + 16'd1;

    always_comb begin
        n_phase    = r_phase;
        n_length   = r_length;
        n_base     = r_base;
        n_count    = r_count;
        n_exec     = r_exec;
        n_sections = r_sections;
        n_aborted  = r_aborted;
        ev         = EV_HEADER;
        dbyte      = '0;
        daddr      = '0;
        if (r_aborted) begin
            ev = EV_IGNORED;
        end else begin
            unique case (r_phase)
                PH_MAGIC_FIRST: begin
                    if (i_byte == MAGIC_SECTION) begin
                        n_phase = PH_LEN_HI;
                    end else begin
                        ev        = EV_BADMAGIC;
                        n_aborted = 1'b1;
                    end
                end
                PH_LEN_HI: begin
                    n_length = {i_byte, {BYTE_W{1'b0}}};
                    n_phase  = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_length = {r_length[WORD_W-1:BYTE_W], i_byte};
                    n_phase  = PH_ADDR_HI;
                end
                PH_ADDR_HI: begin
                    n_base  = {i_byte, {BYTE_W{1'b0}}};
                    n_phase = PH_ADDR_LO;
                end
                PH_ADDR_LO: begin
                    n_base  = {r_base[WORD_W-1:BYTE_W], i_byte};
                    n_count = '0;
                    if (r_sections != COUNT_MAX) begin
                        n_sections = r_sections + 16'd1;
                    end
                    n_phase = (r_length == '0) ? PH_MAGIC_NEXT : PH_DATA;
                    ev      = EV_SECTION;
                end
                PH_DATA: begin
                    ev      = EV_DATA;
                    dbyte   = i_byte;
                    daddr   = r_base + r_count;
                    n_count = count_inc;
                    if (count_inc >= r_length) begin
                        n_phase = PH_MAGIC_NEXT;
                    end
                end
                PH_MAGIC_NEXT: begin
                    if (i_byte == MAGIC_SECTION) begin
                        n_phase = PH_LEN_HI;
                    end else if (i_byte == MAGIC_POSTAMBLE) begin
                        n_phase = PH_FILL_A;
                    end else begin
                        ev        = EV_BADMAGIC;
                        n_aborted = 1'b1;
                    end
                end
                PH_FILL_A: begin
                    if (i_byte != FILL_BYTE) begin
                        ev = EV_WARN;
                    end
                    n_phase = PH_FILL_B;
                end
                PH_FILL_B: begin
                    if (i_byte != FILL_BYTE) begin
                        ev = EV_WARN;
                    end
                    n_phase = PH_EXEC_HI;
                end
                PH_EXEC_HI: begin
                    n_exec  = {i_byte, {BYTE_W{1'b0}}};
                    n_phase = PH_EXEC_LO;
                end
                PH_EXEC_LO: begin
                    n_exec  = {r_exec[WORD_W-1:BYTE_W], i_byte};
                    n_phase = PH_DONE;
                    ev      = EV_EXEC;
                end
                default: begin
                    ev        = EV_AFTEREND;
                    n_aborted = 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        o_res.ev            = ev;
        o_res.data_byte     = dbyte;
        o_res.data_addr     = daddr;
        o_res.section_addr  = n_base;
        o_res.section_len   = n_length;
        o_res.section_count = n_sections;
        o_res.exec_addr     = n_exec;
        if (!i_last) begin
            o_res.file_status = ST_NOT_LAST;
        end else if (n_phase == PH_DONE && !n_aborted) begin
            o_res.file_status = ST_COMPLETE;
        end else begin
            o_res.file_status = ST_INCOMPLETE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_MAGIC_FIRST;
            r_length   <= '0;
            r_base     <= '0;
            r_count    <= '0;
            r_exec     <= '0;
            r_sections <= '0;
            r_aborted  <= 1'b0;
        end else if (i_fire) begin
            r_phase    <= n_phase;
            r_length   <= n_length;
            r_base     <= n_base;
            r_count    <= n_count;
            r_exec     <= n_exec;
            r_sections <= n_sections;
            r_aborted  <= n_aborted;
        end
    end

`ifndef SYNTHESIS
    a_abort_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_aborted |=> r_aborted)
        else $error("abort flag cleared without reset");

    a_ignored_after_abort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && r_aborted) |-> (o_res.ev == EV_IGNORED))
        else $error("byte after abort not ignored");

    a_sections_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire |=> (r_sections >= $past(r_sections)))
        else $error("section count went backwards");

    a_data_in_section: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_res.ev == EV_DATA) |-> (r_count < r_length))
        else $error("data byte beyond section length");
`endif

endmodule

// File: rtl/lrsp_out_stage.sv
// lrsp_out_stage: result register between the parser and the output stream
// holds one result until the downstream transfer completes
// depends on lrsp_pkg
`timescale 1ns / 1ps

module lrsp_out_stage
    import lrsp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    output logic    o_can_load,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_res      = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

// File: rtl/load_record_stream_parser.sv
// load_record_stream_parser: top level, byte stream in, parse results out
// one result per input byte: event code, data byte with address, header state
// depends on lrsp_pkg, lrsp_core, lrsp_out_stage
//
// usage
//   input stream: one file byte per transfer in s_axis_tdata, tlast on the
//   final byte of the file
//   output stream: one result per input byte, event code in m_axis_tuser,
//   data byte, addresses, section count and file status in m_axis_tdata
//   output: result is registered, valid in the cycle after its input transfer
//   throughput: one byte per cycle outside stalls, set by the single result
//   register; a new byte is taken while the previous result is transferred
//   stall: when the receiver holds tready low with a result waiting,
//   s_axis_tready drops in the same cycle and the result stays unchanged
//   reset: synchronous, active low; parser returns to waiting for the first
//   section magic byte, all header registers and counts clear, no result is
//   pending
//   abort: a bad magic byte or a byte after the execution address stops
//   parsing until reset; later bytes still get a result each
`timescale 1ns / 1ps

module load_record_stream_parser
    import lrsp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [BYTE_W-1:0]     s_axis_tdata,   // byte_in
    input  logic                  s_axis_tlast,   // end_of_input
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // data_byte, data_addr, section_addr, section_len, section_count,
    // exec_addr, file_status, zero fill
    output logic [RES_DATA_W-1:0] m_axis_tdata,
    output logic [EVENT_W-1:0]    m_axis_tuser    // event_res
);

    logic    fire;
    logic    can_load;
    t_result step_res;
    t_result out_res;

    assign s_axis_tready = can_load;
    assign fire          = s_axis_tvalid && can_load;

    lrsp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .o_res   (step_res)
    );

    lrsp_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (fire),
        .i_res      (step_res),
        .o_can_load (can_load),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_res      (out_res)
    );

    assign m_axis_tuser = out_res.ev;
    assign m_axis_tdata = {{(RES_DATA_W - RES_BITS){1'b0}},
                           out_res.file_status,
                           out_res.exec_addr,
                           out_res.section_count,
                           out_res.section_len,
                           out_res.section_addr,
                           out_res.data_addr,
                           out_res.data_byte};

endmodule
